[rtl/mrpt_pkg.sv]
// Shared types and constants for the Miller-Rabin prime test block.
// No dependencies.
package mrpt_pkg;
   localparam int unsigned NumWidth = 63;
   localparam int unsigned AccWidth = 64;
   localparam int unsigned BitIdxWidth = 6;
   localparam int unsigned BaseTableSize = 12;
   localparam int unsigned BaseIdxWidth = 4;

   typedef logic [NumWidth-1:0] num_type;

   // mul unit control
   typedef struct packed {
      logic    start;
      num_type x;
      num_type y;
      num_type m;
   } mul_req_type;

   typedef struct packed {
      logic    done;
      num_type prod;
   } mul_rsp_type;

   function automatic num_type base_lookup(input logic [BaseIdxWidth-1:0] idx);
      num_type b;
      unique case (idx)
         4'd0: b = 63'd2;
         4'd1: b = 63'd3;
         4'd2: b = 63'd5;
         4'd3: b = 63'd7;
         4'd4: b = 63'd11;
         4'd5: b = 63'd13;
         4'd6: b = 63'd17;
         4'd7: b = 63'd19;
         4'd8: b = 63'd23;
         4'd9: b = 63'd29;
         4'd10: b = 63'd31;
         4'd11: b = 63'd37;
         default: b = 63'd37;
      endcase
      return b;
   endfunction
endpackage

[rtl/mrpt_mulmod.sv]
// Serial shift-and-add modular multiplier, one bit of y per cycle.
// Depends on mrpt_pkg.
module mrpt_mulmod (
   input  logic                 clock,
   input  logic                 reset,
   input  mrpt_pkg::mul_req_type req,
   output mrpt_pkg::mul_rsp_type rsp
);
   logic                               busy_ff, busy_in;
   logic [mrpt_pkg::BitIdxWidth-1:0]   bit_ff, bit_in;
   mrpt_pkg::num_type                  acc_ff, acc_in;
   mrpt_pkg::num_type                  x_ff, y_ff, m_ff;
   logic                               done_ff, done_in;
   logic [mrpt_pkg::AccWidth-1:0]      dbl, dbl_r, add, add_r;

   always_comb begin
      dbl   = {acc_ff, 1'b0};
      dbl_r = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      add   = dbl_r + {1'b0, x_ff};
      add_r = (add >= {1'b0, m_ff}) ? add - {1'b0, m_ff} : add;
      busy_in = busy_ff;
      bit_in  = bit_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         acc_in = y_ff[bit_ff] ? add_r[mrpt_pkg::NumWidth-1:0]
                               : dbl_r[mrpt_pkg::NumWidth-1:0];
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         bit_in  = mrpt_pkg::BitIdxWidth'(mrpt_pkg::NumWidth - 1);
         acc_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      acc_ff <= acc_in;
      if (!busy_ff && req.start) begin
         x_ff <= req.x;
         y_ff <= req.y;
         m_ff <= req.m;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_acc_below_mod: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> acc_ff < m_ff) else $error("product not reduced");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> (busy_ff || done_ff)) else $error("busy dropped early");
`endif
endmodule

[rtl/miller_rabin_prime_test.sv]
// Miller-Rabin prime test for 63-bit candidates: one result per candidate.
// Trivial candidates (below 4 or even) go straight to S_DONE and then rsp_tvalid;
// otherwise each base runs a modular power and squaring chain on the one serial
// multiplier, for up to NUM_BASES bases (capped at the 12-entry base table).
// One candidate at a time; req_tready is low while a test runs.
// Synchronous active-high reset clears the sequencer and result valid.
module miller_rabin_prime_test #(
   parameter int unsigned NUM_BASES = 9
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] candidate
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] is_prime
);
   localparam int unsigned NB = (NUM_BASES > mrpt_pkg::BaseTableSize) ?
                                mrpt_pkg::BaseTableSize : NUM_BASES;

   typedef enum logic [3:0] {
      S_IDLE, S_SPLIT, S_BASE, S_PMUL, S_PSQ, S_CHECK, S_SQR, S_SQCHK, S_DONE
   } state_type;

   state_type                          state_ff, state_in;
   mrpt_pkg::num_type                  n_ff, n_in, d_ff, d_in, e_ff, e_in;
   mrpt_pkg::num_type                  res_ff, res_in, sq_ff, sq_in;
   logic [mrpt_pkg::BitIdxWidth-1:0]   s_ff, s_in, r_ff, r_in;
   logic [mrpt_pkg::BaseIdxWidth-1:0]  bi_ff, bi_in;
   logic                               prime_ff, prime_in;
   logic                               valid_ff, valid_in;
   logic                               wait_ff, wait_in;
   mrpt_pkg::mul_req_type              mreq;
   mrpt_pkg::mul_rsp_type              mrsp;
   mrpt_pkg::num_type                  base, nm1;

   mrpt_mulmod u_mul (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign base = mrpt_pkg::base_lookup(bi_ff);
   assign nm1  = n_ff - 1'b1;

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; d_in = d_ff; e_in = e_ff; res_in = res_ff; sq_in = sq_ff;
      s_in = s_ff; r_in = r_ff; bi_in = bi_ff; prime_in = prime_ff;
      valid_in = valid_ff; wait_in = wait_ff;
      mreq = '{start: 1'b0, x: res_ff, y: sq_ff, m: n_ff};
      if (valid_ff && rsp_tready) valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !valid_ff) begin
               n_in = req_tdata[62:0];
               priority if (req_tdata[62:0] < 63'd2) begin
                  prime_in = 1'b0; state_in = S_DONE;
               end else if (req_tdata[62:0] <= 63'd3) begin
                  prime_in = 1'b1; state_in = S_DONE;
               end else if (!req_tdata[0]) begin
                  prime_in = 1'b0; state_in = S_DONE;
               end else begin
                  d_in = req_tdata[62:0] - 1'b1; s_in = '0; bi_in = '0;
                  state_in = S_SPLIT;
               end
            end
         end
         S_SPLIT: begin
            if (!d_ff[0]) begin
               d_in = d_ff >> 1; s_in = s_ff + 1'b1;
            end else begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            if (bi_ff >= mrpt_pkg::BaseIdxWidth'(NB) || base > n_ff - 63'd2) begin
               prime_in = 1'b1; state_in = S_DONE;
            end else begin
               res_in = 63'd1; sq_in = base; e_in = d_ff; wait_in = 1'b0;
               state_in = S_PMUL;
            end
         end
         S_PMUL: begin
            // multiply res by sq when the low exponent bit is set
            if (e_ff == '0) begin
               r_in = 6'd1; state_in = S_CHECK;
            end else if (!e_ff[0]) begin
               state_in = S_PSQ;
            end else if (!wait_ff) begin
               mreq.start = 1'b1; mreq.x = res_ff; mreq.y = sq_ff;
               wait_in = 1'b1;
            end else if (mrsp.done) begin
               res_in = mrsp.prod; wait_in = 1'b0; state_in = S_PSQ;
            end
         end
         S_PSQ: begin
            if (!wait_ff) begin
               mreq.start = 1'b1; mreq.x = sq_ff; mreq.y = sq_ff;
               wait_in = 1'b1;
            end else if (mrsp.done) begin
               sq_in = mrsp.prod; wait_in = 1'b0; e_in = e_ff >> 1;
               state_in = S_PMUL;
            end
         end
         S_CHECK: begin
            if (res_ff == 63'd1 || res_ff == nm1) begin
               bi_in = bi_ff + 1'b1; state_in = S_BASE;
            end else if (r_ff >= s_ff) begin
               prime_in = 1'b0; state_in = S_DONE;
            end else begin
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            if (!wait_ff) begin
               mreq.start = 1'b1; mreq.x = res_ff; mreq.y = res_ff;
               wait_in = 1'b1;
            end else if (mrsp.done) begin
               res_in = mrsp.prod; wait_in = 1'b0; state_in = S_SQCHK;
            end
         end
         S_SQCHK: begin
            priority if (res_ff == nm1) begin
               bi_in = bi_ff + 1'b1; state_in = S_BASE;
            end else if (res_ff == 63'd1 || r_ff + 1'b1 >= s_ff) begin
               prime_in = 1'b0; state_in = S_DONE;
            end else begin
               r_in = r_ff + 1'b1; state_in = S_SQR;
            end
         end
         S_DONE: begin
            valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         wait_ff  <= wait_in;
      end
      n_ff <= n_in; d_ff <= d_in; e_ff <= e_in; res_ff <= res_in; sq_ff <= sq_in;
      s_ff <= s_in; r_ff <= r_in; bi_ff <= bi_in; prime_ff <= prime_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !valid_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, prime_ff};

`ifndef SYNTHESIS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(prime_ff)))
      else $error("result lost");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_tvalid) else $error("no result");
`endif
endmodule

[tb/testbench.sv]
// Testbench for miller_rabin_prime_test: drives candidates over the request stream
// and checks each primality verdict against a local Miller-Rabin predictor or a directed row's known value.
// Depends on the RTL top miller_rabin_prime_test only.
`timescale 1ns / 1ps

module testbench;
   localparam int unsigned NUM_BASES = 9;
   localparam int unsigned BASE_COUNT = 12;
   localparam logic [63:0] CAND_MASK = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [63:0] word;
      bit          has_known;
      bit          known;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [62:0] candidate
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] is_prime

   bit          verdict_q[$];
   int          errors;
   int          sent;
   int          got;
   int          prime_seen;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          recv_run;

   logic [63:0] base_tab[BASE_COUNT] = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
                                         64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37};

   miller_rabin_prime_test #(.NUM_BASES(NUM_BASES)) u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [127:0] p;
      p = x * y;
      return 64'(p % m);
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
      logic [63:0] r;
      logic [63:0] sq;
      r = 64'd1 % m;
      sq = b % m;
      while (e != 0) begin
         if (e[0]) r = mul_mod(r, sq, m);
         sq = mul_mod(sq, sq, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic bit predict_prime(logic [63:0] word);
      logic [63:0] n;
      logic [63:0] d;
      logic [63:0] x;
      int          s;
      bit          composite;
      n = word & CAND_MASK;
      if (n < 2) return 1'b0;
      if (n <= 3) return 1'b1;
      if (!n[0]) return 1'b0;
      d = n - 1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < NUM_BASES && i < BASE_COUNT; i++) begin
         if (base_tab[i] > n - 2) break;
         x = pow_mod(base_tab[i], d, n);
         if (x == 1 || x == n - 1) continue;
         composite = 1'b1;
         for (int r = 1; r < s; r++) begin
            x = mul_mod(x, x, n);
            if (x == n - 1) begin
               composite = 1'b0;
               break;
            end
            if (x == 1) break;
         end
         if (composite) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Send one candidate; hold valid until the transfer completes.
   // Valid stays high after the transfer unless the next call idles.
   task automatic send_candidate(logic [63:0] word, bit has_known, bit known);
      bit p;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      p = predict_prime(word);
      if (has_known && p != known) begin
         $error("directed row %0h: table says %0b, predictor %0b", word, known, p);
         errors++;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      verdict_q.push_back(has_known ? known : p);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
   endtask

   // Receiver: random stall, check every transfer against the oldest verdict.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got++;
            if (verdict_q.size() == 0) begin
               $error("unexpected result: is_prime=%0b", rsp_tdata[0]);
               errors++;
            end else begin
               bit want;
               want = verdict_q.pop_front();
               if (rsp_tdata[0] !== want) begin
                  $error("is_prime mismatch: expected %0b, actual %0b", want, rsp_tdata[0]);
                  errors++;
               end
               if (want) prime_seen++;
            end
         end
         rsp_tready <= recv_run && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   stim_row_type directed[$] = '{
      '{64'd0, 1, 0}, '{64'd1, 1, 0}, '{64'd2, 1, 1}, '{64'd3, 1, 1},
      '{64'd4, 1, 0}, '{64'd5, 1, 1}, '{64'd7, 1, 1}, '{64'd9, 1, 0},
      '{64'd25, 1, 0}, '{64'd29, 0, 0}, '{64'd561, 1, 0}, '{64'd2047, 1, 0},
      '{64'd3215031751, 1, 0}, '{64'd1000000007, 1, 1},
      '{64'h7FFF_FFFF_FFFF_FFFF, 0, 0}, '{64'h7FFF_FFFF_FFFF_FFFE, 1, 0},
      '{64'h7FFF_FFFF_FFFF_FFE7, 0, 0}, '{64'hFFFF_FFFF_FFFF_FFFF, 0, 0},
      '{64'h8000_0000_0000_0005, 1, 1}, '{64'h8000_0000_0000_0000, 1, 0},
      '{64'd3825123056546413049, 0, 0}, '{64'h5555_5555_5555_5555, 0, 0},
      '{64'h2AAA_AAAA_AAAA_AAAB, 0, 0}, '{64'd341550071728321, 1, 0}
   };

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      errors = 0; sent = 0; got = 0; prime_seen = 0;
      send_idle_pct = 16; recv_idle_pct = 63; recv_run = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      recv_run = 1'b1;
      foreach (directed[i]) send_candidate(directed[i].word, directed[i].has_known, directed[i].known);
      req_tvalid <= 1'b0;
      // Let the pipe drain once before the random part.
      while (verdict_q.size() != 0) @(posedge clock);
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 63 : 0;
         recv_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 16 : 0;
         for (int k = 0; k < 26; k++) begin
            logic [63:0] w;
            w = {$urandom, $urandom};
            case ($urandom_range(3))
               0: w = w & 64'hFFFF;                  // small odd/even values
               1: w = w & 64'hFFFF_FFFF;
               2: w = w | 64'd1;
               default: ;
            endcase
            if ($urandom_range(1)) w[0] = 1'b1;
            send_candidate(w, 0, 0);
         end
      end
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Checked %0d candidates (%0d prime) incl. extremes, masked top bit, strong",
               got, prime_seen);
      $display("pseudoprimes and three idle patterns on both stream sides.");
      if (errors == 0 && verdict_q.size() == 0 && got == sent)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #1000ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule

[sim.f]
rtl/mrpt_pkg.sv
rtl/mrpt_mulmod.sv
rtl/miller_rabin_prime_test.sv
tb/testbench.sv
